// File: hdl/time_of_day_clock_ascii_macros.svh
// Assertion macros for the time-of-day clock.
// Each macro is active in simulation and empty in synthesis.
`ifndef TIME_OF_DAY_CLOCK_ASCII_MACROS_SVH
`define TIME_OF_DAY_CLOCK_ASCII_MACROS_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define TOD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tod: same-cycle check failed");
// Check cons in the cycle after ante.
`define TOD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tod: next-cycle check failed");
`else
`define TOD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TOD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/tod_pkg.sv
`default_nettype none
package tod_pkg;

    // Default prescaler width and queue depth
    localparam int TICK_COUNT_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF     = 2;

    // Configuration register
    localparam int          TPS_BITS  = 16;
    localparam logic [15:0] TPS_RESET = 16'd1000;

    // Request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    // Limits of the time fields
    localparam logic [4:0] HOUR_MAX = 5'd23;
    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [5:0] SEC_MAX  = 6'd59;

    typedef struct packed {
        logic       req_type;
        logic [7:0] hour_tens_char;
        logic [7:0] hour_units_char;
        logic [7:0] minute_tens_char;
        logic [7:0] minute_units_char;
        logic [7:0] second_tens_char;
        logic [7:0] second_units_char;
    } t_tod_in;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
        logic [4:0] hour_now;
        logic [5:0] minute_now;
        logic [5:0] second_now;
    } t_tod_out;

    // Snapshot of the time handed from front to back
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod_hms;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic     valid;
        t_tod_hms tval;
    } t_tod_head;

endpackage
`default_nettype wire

// File: hdl/tod_front.sv
`default_nettype none
`include "time_of_day_clock_ascii_macros.svh"
module tod_front #(
    parameter int TICK_COUNT_BITS = tod_pkg::TICK_COUNT_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  tod_pkg::t_tod_in                  i_data,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [tod_pkg::TPS_BITS-1:0]       i_cfg_data,
    input  wire                               i_q_full,
    output logic                              o_push,
    output tod_pkg::t_tod_hms                 o_push_data
);

    localparam int CMP_W = (TICK_COUNT_BITS > tod_pkg::TPS_BITS) ?
                           TICK_COUNT_BITS : tod_pkg::TPS_BITS;

    logic [tod_pkg::TPS_BITS-1:0] r_tps;
    logic [TICK_COUNT_BITS-1:0]   r_count;
    tod_pkg::t_tod_hms            r_time;

    logic [TICK_COUNT_BITS-1:0]   n_count;
    tod_pkg::t_tod_hms            n_time;
    tod_pkg::t_tod_hms            set_time;
    logic                         accept;
    logic                         roll;
    logic                         set_ok;
    logic [6:0]                   set_h;
    logic [6:0]                   set_m;
    logic [6:0]                   set_s;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [6:0] two_digits(input logic [7:0] t, input logic [7:0] u);
        logic [3:0] dt;
        logic [3:0] du;
        dt = t[3:0] - 4'd0;
        du = u[3:0];
        // '0' is 0x30, so the low nibble is the digit value
        two_digits = 7'(dt) * 7'd10 + 7'(du);
    endfunction

    // Stall whenever the snapshot queue is full, whatever the request type
    assign o_ready     = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    // Prescaler
    assign n_count = r_count + TICK_COUNT_BITS'(1);
    assign roll    = CMP_W'(n_count) >= CMP_W'(r_tps);

    // Advance one second with rollover
    always_comb begin
        n_time = r_time;
        if (r_time.second >= tod_pkg::SEC_MAX) begin
            n_time.second = '0;
            if (r_time.minute >= tod_pkg::MIN_MAX) begin
                n_time.minute = '0;
                n_time.hour   = (r_time.hour >= tod_pkg::HOUR_MAX) ? 5'd0
                                                                    : r_time.hour + 5'd1;
            end else begin
                n_time.minute = r_time.minute + 6'd1;
            end
        end else begin
            n_time.second = r_time.second + 6'd1;
        end
    end

    // Decode and check a set request
    always_comb begin
        set_h  = two_digits(i_data.hour_tens_char, i_data.hour_units_char);
        set_m  = two_digits(i_data.minute_tens_char, i_data.minute_units_char);
        set_s  = two_digits(i_data.second_tens_char, i_data.second_units_char);
        set_ok = is_digit(i_data.hour_tens_char) && is_digit(i_data.hour_units_char) &&
                 is_digit(i_data.minute_tens_char) && is_digit(i_data.minute_units_char) &&
                 is_digit(i_data.second_tens_char) && is_digit(i_data.second_units_char) &&
                 (set_h <= 7'(tod_pkg::HOUR_MAX)) && (set_m <= 7'(tod_pkg::MIN_MAX)) &&
                 (set_s <= 7'(tod_pkg::SEC_MAX));
        set_time.hour   = set_h[4:0];
        set_time.minute = set_m[5:0];
        set_time.second = set_s[5:0];
    end

    assign o_push      = accept && (i_data.req_type == tod_pkg::REQ_TICK) && roll;
    assign o_push_data = n_time;

    // Hold the register, prescaler and time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps   <= tod_pkg::TPS_RESET;
            r_count <= '0;
            r_time  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_tps <= i_cfg_data;
            end
            if (accept) begin
                if (i_data.req_type == tod_pkg::REQ_TICK) begin
                    if (roll) begin
                        r_count <= '0;
                        r_time  <= n_time;
                    end else begin
                        r_count <= n_count;
                    end
                end else if (set_ok) begin
                    r_time <= set_time;
                end
            end
        end
    end

    `TOD_ASSERT_SAME(a_front_range, i_clk, i_rst_n, 1'b1, (r_time.hour <= tod_pkg::HOUR_MAX) && (r_time.minute <= tod_pkg::MIN_MAX) && (r_time.second <= tod_pkg::SEC_MAX))
    `TOD_ASSERT_NEXT(a_front_set_keeps_count, i_clk, i_rst_n, accept && (i_data.req_type == tod_pkg::REQ_SET), r_count == $past(r_count))

endmodule
`default_nettype wire

// File: hdl/tod_queue.sv
`default_nettype none
`include "time_of_day_clock_ascii_macros.svh"
module tod_queue #(
    parameter int DEPTH = tod_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  tod_pkg::t_tod_hms     i_push_data,
    output logic                  o_full,
    input  wire                   i_pop,
    output tod_pkg::t_tod_head    o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tod_pkg::t_tod_hms r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.tval = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_head.valid;

    // Store a pushed word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `TOD_ASSERT_SAME(a_queue_no_overflow, i_clk, i_rst_n, o_full, !i_push)
    `TOD_ASSERT_SAME(a_queue_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

// File: hdl/tod_back.sv
`default_nettype none
`include "time_of_day_clock_ascii_macros.svh"
module tod_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  tod_pkg::t_tod_head    i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire                   i_ready,
    output tod_pkg::t_tod_out     o_data
);

    // Character positions in the string
    localparam logic [3:0] POS_HOUR_T = 4'd0;
    localparam logic [3:0] POS_HOUR_U = 4'd1;
    localparam logic [3:0] POS_COLON1 = 4'd2;
    localparam logic [3:0] POS_MIN_T  = 4'd3;
    localparam logic [3:0] POS_MIN_U  = 4'd4;
    localparam logic [3:0] POS_COLON2 = 4'd5;
    localparam logic [3:0] POS_SEC_T  = 4'd6;
    localparam logic [3:0] POS_SEC_U  = 4'd7;
    localparam logic [3:0] POS_LF     = 4'd8;
    localparam logic [3:0] POS_CR     = 4'd9;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    logic              r_busy;
    logic [3:0]        r_idx;
    tod_pkg::t_tod_hms r_time;

    logic              take;
    logic              fin;
    logic              load;
    logic [7:0]        ch;

    // Tens digit of a value below 64
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        if (v >= 6'd60)      tens_of = 4'd6;
        else if (v >= 6'd50) tens_of = 4'd5;
        else if (v >= 6'd40) tens_of = 4'd4;
        else if (v >= 6'd30) tens_of = 4'd3;
        else if (v >= 6'd20) tens_of = 4'd2;
        else if (v >= 6'd10) tens_of = 4'd1;
        else                 tens_of = 4'd0;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] t;
        t = 6'(tens_of(v));
        units_of = 4'(v - ((t << 3) + (t << 1)));
    endfunction

    assign take  = o_valid && i_ready;
    assign fin   = take && (r_idx == POS_CR);
    assign load  = (!r_busy || fin) && i_head.valid;
    assign o_pop = load;

    // Pick the character for the current position
    always_comb begin
        unique case (r_idx)
            POS_HOUR_T: ch = CH_ZERO + 8'(tens_of(6'(r_time.hour)));
            POS_HOUR_U: ch = CH_ZERO + 8'(units_of(6'(r_time.hour)));
            POS_COLON1: ch = CH_COLON;
            POS_MIN_T:  ch = CH_ZERO + 8'(tens_of(r_time.minute));
            POS_MIN_U:  ch = CH_ZERO + 8'(units_of(r_time.minute));
            POS_COLON2: ch = CH_COLON;
            POS_SEC_T:  ch = CH_ZERO + 8'(tens_of(r_time.second));
            POS_SEC_U:  ch = CH_ZERO + 8'(units_of(r_time.second));
            POS_LF:     ch = CH_LF;
            POS_CR:     ch = CH_CR;
            default:    ch = CH_CR;
        endcase
    end

    assign o_valid           = r_busy;
    assign o_data.text_char  = ch;
    assign o_data.last_char  = (r_idx == POS_CR);
    assign o_data.hour_now   = r_time.hour;
    assign o_data.minute_now = r_time.minute;
    assign o_data.second_now = r_time.second;

    // Walk the string one word per accepted cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= POS_HOUR_T;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= POS_HOUR_T;
        end else if (fin) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    // Hold the snapshot being printed
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_time <= i_head.tval;
        end
    end

    `TOD_ASSERT_SAME(a_back_idx_range, i_clk, i_rst_n, r_busy, r_idx <= POS_CR)
    `TOD_ASSERT_NEXT(a_back_drain, i_clk, i_rst_n, fin && !i_head.valid, !o_valid)

endmodule
`default_nettype wire

// File: hdl/time_of_day_clock_ascii.sv
// Channel | Dir | Handshake                   | Word
// --------+-----+-----------------------------+-------------------------------
// request | in  | i_valid / o_ready           | tod_pkg::t_tod_in  (i_data)
// result  | out | o_valid / i_ready           | tod_pkg::t_tod_out (o_data)
// config  | in  | i_cfg_valid / o_cfg_ready   | ticks_per_second   (i_cfg_data)
//
// Ticks and sets may arrive every cycle while o_ready is high. A rollover
// tick queues a time snapshot; the printer sends its ten words at one word
// per cycle while i_ready is high, and loads the next queued snapshot as its
// last word is taken. o_ready drops only while the snapshot queue is full.
// Synchronous active-low reset: time 00:00:00, prescaler 0, ticks_per_second 1000.
`default_nettype none
module time_of_day_clock_ascii #(
    parameter int TICK_COUNT_BITS = tod_pkg::TICK_COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH     = tod_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  tod_pkg::t_tod_in             i_data,
    output logic                         o_valid,
    input  wire                          i_ready,
    output tod_pkg::t_tod_out            o_data,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [tod_pkg::TPS_BITS-1:0]  i_cfg_data
);

    logic               q_full;
    logic               push;
    tod_pkg::t_tod_hms  push_data;
    logic               pop;
    tod_pkg::t_tod_head head;

    tod_front #(
        .TICK_COUNT_BITS(TICK_COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    tod_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_head      (head)
    );

    tod_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire
